// ===== rtl/core/classifier_vote_smoother_core_macros.svh =====
// Assertion macros for the vote smoother core.
`ifndef CLASSIFIER_VOTE_SMOOTHER_CORE_MACROS_SVH
`define CLASSIFIER_VOTE_SMOOTHER_CORE_MACROS_SVH

// Same-cycle implication.
`define CVS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vote smoother check failed");

// Next-cycle implication.
`define CVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vote smoother check failed");

`endif

// ===== rtl/core/cvs_pkg.sv =====
package cvs_pkg;

  localparam int THR_W = 3;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_CONF_MIN = 2'd0;
  localparam cfg_idx_t CFG_MARG_MIN = 2'd1;
  localparam cfg_idx_t CFG_VOTE_THR = 2'd2;

  localparam int CONF_MIN_RESET = 39322;
  localparam int MARG_MIN_RESET = 9830;
  localparam logic [THR_W-1:0] VOTE_THR_RESET = 3'd3;
  localparam logic [7:0] UNKNOWN_CLASS = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_LOAD   = 4'b1000
  } state_t;

  typedef struct packed {
    logic run_step;
    logic decide;
    logic scan_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_pending;
    logic known;
    logic scan_done;
  } sts_t;

endpackage

// ===== rtl/core/cvs_ctrl.sv =====
module cvs_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         run_last,
  output logic         in_stall,
  input  cvs_pkg::sts_t sts,
  output cvs_pkg::cmd_t cmd
);
  import cvs_pkg::*;

  state_t state;
  state_t state_next;
  logic   xfer;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    xfer = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = run_last && sts.out_pending;
        xfer = in_valid && !in_stall;
        cmd.run_step = xfer;
        if (xfer && run_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = sts.known ? ST_SCAN : ST_LOAD;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/cvs_datapath.sv =====
module cvs_datapath #(
  parameter int NUM_CLASSES = 8,
  parameter int VOTE_WINDOW = 5,
  parameter int PROB_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  cvs_pkg::cfg_idx_t        cfg_index,
  input  logic [PROB_BITS-1:0]     cfg_data,
  input  logic [PROB_BITS-1:0]     probability,
  input  logic signed [7:0]        raw_class,
  input  cvs_pkg::cmd_t            cmd,
  output cvs_pkg::sts_t            sts,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               smoothed_class,
  output logic [PROB_BITS-1:0]     confidence,
  output logic [PROB_BITS-1:0]     top_margin,
  output logic                     unknown_flag
);
  import cvs_pkg::*;

  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int EL_W   = $clog2(NUM_CLASSES + 1);
  localparam int IDX_W  = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
  localparam int FILL_W = $clog2(VOTE_WINDOW + 1);
  localparam int CMP_W  = (FILL_W > THR_W) ? FILL_W : THR_W;

  logic [PROB_BITS-1:0] conf_min;
  logic [PROB_BITS-1:0] marg_min;
  logic [THR_W-1:0]     vote_thr;

  logic [PROB_BITS-1:0] best_prob;
  logic [PROB_BITS-1:0] second_prob;
  logic [PROB_BITS-1:0] captured_conf;
  logic [EL_W-1:0]      element_index;
  logic [CLS_W-1:0]     raw_cls;
  logic                 in_range;

  logic [CLS_W-1:0]     ring [VOTE_WINDOW];
  logic [FILL_W-1:0]    fill;
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     scan_idx;
  logic                 found;
  logic [CLS_W-1:0]     best_cls;
  logic                 known;
  logic [7:0]           held_class;
  logic [7:0]           held_next;
  logic [PROB_BITS-1:0] conf_r;
  logic [PROB_BITS-1:0] margin_r;

  logic [7:0]           raw_u;
  logic                 item_in_range;
  logic                 active;
  logic [PROB_BITS-1:0] dec_conf;
  logic [PROB_BITS-1:0] dec_margin;
  logic                 dec_known;
  logic [CLS_W-1:0]     cand;
  logic [FILL_W-1:0]    vote_cnt;
  logic                 hit;

  assign raw_u = unsigned'(raw_class);
  assign item_in_range = !raw_class[7] && (raw_u < 8'(NUM_CLASSES));
  assign active = element_index != EL_W'(NUM_CLASSES);

  assign dec_conf = in_range ? captured_conf : '0;
  assign dec_margin = (element_index >= EL_W'(2)) ? best_prob - second_prob : '0;
  assign dec_known = in_range && !(dec_conf < conf_min) && !(dec_margin < marg_min);

  assign cand = ring[scan_idx];

  always_comb begin
    vote_cnt = '0;
    for (int j = 0; j < VOTE_WINDOW; j++) begin
      if ((FILL_W'(j) < fill) && (ring[j] == cand)) begin
        vote_cnt = vote_cnt + FILL_W'(1);
      end
    end
  end

  assign hit = CMP_W'(vote_cnt) >= CMP_W'(vote_thr);
  assign held_next = (known && found) ? 8'(best_cls) : held_class;

  assign sts.out_pending = out_valid;
  assign sts.known = dec_known;
  assign sts.scan_done = FILL_W'(scan_idx) == (fill - FILL_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_min <= PROB_BITS'(CONF_MIN_RESET);
      marg_min <= PROB_BITS'(MARG_MIN_RESET);
      vote_thr <= VOTE_THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CONF_MIN: conf_min <= cfg_data;
        CFG_MARG_MIN: marg_min <= cfg_data;
        CFG_VOTE_THR: vote_thr <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_prob <= '0;
      second_prob <= '0;
      captured_conf <= '0;
      element_index <= '0;
    end else if (cmd.decide) begin
      best_prob <= '0;
      second_prob <= '0;
      captured_conf <= '0;
      element_index <= '0;
    end else if (cmd.run_step && active) begin
      if (element_index == '0) begin
        best_prob <= probability;
      end else if (probability > best_prob) begin
        second_prob <= best_prob;
        best_prob <= probability;
      end else if ((element_index == EL_W'(1)) || (probability > second_prob)) begin
        second_prob <= probability;
      end
      if (item_in_range && (raw_u == 8'(element_index))) begin
        captured_conf <= probability;
      end
      element_index <= element_index + EL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_step) begin
      raw_cls <= raw_u[CLS_W-1:0];
      in_range <= item_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && dec_known) begin
      ring[pos] <= raw_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pos <= '0;
      held_class <= UNKNOWN_CLASS;
      known <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide) begin
        known <= dec_known;
        if (dec_known) begin
          pos <= (pos == IDX_W'(VOTE_WINDOW - 1)) ? '0 : pos + IDX_W'(1);
          if (fill != FILL_W'(VOTE_WINDOW)) begin
            fill <= fill + FILL_W'(1);
          end
          found <= vote_thr == '0;
        end
      end
      if (cmd.scan_step && hit && (!found || (cand < best_cls))) begin
        found <= 1'b1;
      end
      if (cmd.load) begin
        held_class <= held_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      conf_r <= dec_conf;
      margin_r <= dec_margin;
      scan_idx <= '0;
      best_cls <= '0;
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (hit && (!found || (cand < best_cls))) begin
        best_cls <= cand;
      end
    end
    if (cmd.load) begin
      smoothed_class <= held_next;
      confidence <= conf_r;
      top_margin <= margin_r;
      unknown_flag <= !known;
    end
  end

endmodule

// ===== rtl/core/classifier_vote_smoother_core.sv =====
// Classifier vote smoother. Feed one class probability per transfer, class 0
// first, with the raw predicted class and run_last on the final transfer.
// Items that do not end a run are taken while the controller is idle. A
// run-ending item leads to a decide state, then, if the prediction is accepted,
// to a scan state where the vote scans the ring of recent classes one entry per
// cycle, and then to load; a prediction rejected as unknown skips the scan. One
// result comes out per run and waits in an output register; items of the next
// run are taken meanwhile, but its last item stalls until that result has been
// taken. Configuration writes are always ready and take effect at once.
module classifier_vote_smoother_core #(
  parameter int NUM_CLASSES = 8,
  parameter int VOTE_WINDOW = 5,
  parameter int PROB_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cvs_pkg::cfg_idx_t    cfg_index,
  input  logic [PROB_BITS-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PROB_BITS-1:0] probability,
  input  logic signed [7:0]    raw_class,
  input  logic                 run_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           smoothed_class,
  output logic [PROB_BITS-1:0] confidence,
  output logic [PROB_BITS-1:0] top_margin,
  output logic                 unknown_flag
);
  import cvs_pkg::*;

  `include "classifier_vote_smoother_core_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .run_last (run_last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cvs_datapath #(
    .NUM_CLASSES (NUM_CLASSES),
    .VOTE_WINDOW (VOTE_WINDOW),
    .PROB_BITS   (PROB_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .probability    (probability),
    .raw_class      (raw_class),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .smoothed_class (smoothed_class),
    .confidence     (confidence),
    .top_margin     (top_margin),
    .unknown_flag   (unknown_flag)
  );

  `CVS_ASSERT_IMPLY(a_end_waits_for_out, clk, rst, in_valid && run_last && out_valid, in_stall)
  `CVS_ASSERT_NEXT(a_busy_after_end, clk, rst, in_valid && !in_stall && run_last, in_stall)
  `CVS_ASSERT_IMPLY(a_load_while_busy, clk, rst, cmd.load, in_stall && !out_valid)

endmodule

// ===== sim/tb_classifier_vote_smoother_core.sv =====
`timescale 1ns / 100ps

module tb_classifier_vote_smoother_core;
  import cvs_pkg::*;

  localparam int NUM_CLASSES = 8;
  localparam int VOTE_WINDOW = 5;
  localparam int PROB_BITS = 16;
  localparam int INDEX_CAP = 127;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int N_PLAN = 25;

  typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [7:0]  smoothed_class;
    logic [15:0] confidence;
    logic [15:0] top_margin;
    logic        unknown_flag;
  } verdict_t;

  typedef struct {
    logic [15:0]       p;
    logic signed [7:0] rc;
    logic              lst;
    bit                typed;
    verdict_t          want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_CONF_MIN;
  logic [PROB_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PROB_BITS-1:0] probability = '0;
  logic signed [7:0] raw_class = '0;
  logic run_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] smoothed_class;
  logic [PROB_BITS-1:0] confidence;
  logic [PROB_BITS-1:0] top_margin;
  logic unknown_flag;

  classifier_vote_smoother_core #(
    .NUM_CLASSES(NUM_CLASSES),
    .VOTE_WINDOW(VOTE_WINDOW),
    .PROB_BITS(PROB_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .probability(probability),
    .raw_class(raw_class),
    .run_last(run_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .smoothed_class(smoothed_class),
    .confidence(confidence),
    .top_margin(top_margin),
    .unknown_flag(unknown_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Smoother state mirrored from the block
  logic [15:0] conf_min = 16'(CONF_MIN_RESET);
  logic [15:0] marg_min = 16'(MARG_MIN_RESET);
  logic [2:0]  vote_thr = VOTE_THR_RESET;
  logic [15:0] top_prob = '0;
  logic [15:0] runner_prob = '0;
  logic [15:0] raw_conf = '0;
  int          elem_idx = 0;
  logic [2:0]  ring [VOTE_WINDOW];
  int          fill = 0;
  int          pos = 0;
  logic [7:0]  held = UNKNOWN_CLASS;

  verdict_t verdict_q[$];
  int fail_count = 0;
  pace_t pace = PACE_FREE;
  int trend_cls = 1;

  logic [15:0] conf_tab [N_PHASES] =
    '{16'd0, 16'd65535, 16'd30000, 16'd39322, 16'd20000, 16'd25000, 16'd32768,
      16'd45000, 16'd26000};
  logic [15:0] marg_tab [N_PHASES] =
    '{16'd0, 16'd65535, 16'd5000, 16'd9830, 16'd2000, 16'd4000, 16'd8192,
      16'd1, 16'd12000};
  logic [15:0] thr_tab [N_PHASES] =
    '{16'd1, 16'd5, 16'd3, 16'd0, 16'd6, 16'd7, 16'd2, 16'd4, 16'd5};
  pace_t pace_tab [N_PHASES] =
    '{PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH, PACE_FREE,
      PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH, PACE_FREE};

  plan_row_t plan [N_PLAN];

  function automatic bit smooth_step(input logic [15:0] p, input logic signed [7:0] rc,
                                     input logic lst, output verdict_t res);
    int raw_i;
    bit in_rng;
    bit rej;
    bit found;
    int seen;
    logic [15:0] conf;
    logic [15:0] marg;
    int tally [NUM_CLASSES];
    raw_i = int'(rc);
    in_rng = (raw_i >= 0) && (raw_i < NUM_CLASSES);
    res = '0;
    if (elem_idx < NUM_CLASSES) begin
      if (elem_idx == 0) begin
        top_prob = p;
      end else if (p > top_prob) begin
        runner_prob = top_prob;
        top_prob = p;
      end else if (elem_idx == 1 || p > runner_prob) begin
        runner_prob = p;
      end
      if (in_rng && raw_i == elem_idx) raw_conf = p;
    end
    if (elem_idx < INDEX_CAP) elem_idx++;
    if (!lst) return 1'b0;
    seen = (elem_idx < NUM_CLASSES) ? elem_idx : NUM_CLASSES;
    conf = in_rng ? raw_conf : 16'd0;
    marg = (seen >= 2) ? top_prob - runner_prob : 16'd0;
    rej = !in_rng || conf < conf_min || marg < marg_min;
    if (!rej) begin
      ring[pos] = raw_i[2:0];
      pos = (pos + 1) % VOTE_WINDOW;
      if (fill < VOTE_WINDOW) fill++;
      for (int i = 0; i < NUM_CLASSES; i++) tally[i] = 0;
      for (int i = 0; i < fill; i++) tally[ring[i]]++;
      found = 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (!found && tally[i] >= int'(vote_thr)) begin
          held = i[7:0];
          found = 1'b1;
        end
      end
    end
    res.smoothed_class = held;
    res.confidence = conf;
    res.top_margin = marg;
    res.unknown_flag = rej;
    top_prob = '0;
    runner_prob = '0;
    raw_conf = '0;
    elem_idx = 0;
    return 1'b1;
  endfunction

  function automatic bit send_gap();
    case (pace)
      PACE_SEND_IDLE: return $urandom_range(0, 99) < 67;
      PACE_BOTH:      return $urandom_range(0, 99) < 13;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (pace)
      PACE_RECV_STALL: return $urandom_range(0, 99) < 67;
      PACE_BOTH:       return $urandom_range(0, 99) < 13;
      default:         return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : recv_stall();
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (smoothed_class !== want.smoothed_class) begin
          $error("smoothed_class: expected %0d, got %0d", want.smoothed_class, smoothed_class);
          fail_count++;
        end
        if (confidence !== want.confidence) begin
          $error("confidence: expected %0d, got %0d", want.confidence, confidence);
          fail_count++;
        end
        if (top_margin !== want.top_margin) begin
          $error("top_margin: expected %0d, got %0d", want.top_margin, top_margin);
          fail_count++;
        end
        if (unknown_flag !== want.unknown_flag) begin
          $error("unknown_flag: expected %0d, got %0d", want.unknown_flag, unknown_flag);
          fail_count++;
        end
      end
    end
  end

  // Leaves in_valid high after the transfer; callers drop it when done.
  task automatic send_item(input logic [15:0] p, input logic signed [7:0] rc,
                           input logic lst, input bit typed, input verdict_t want);
    verdict_t res;
    while (send_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    probability <= p;
    raw_class <= rc;
    run_last <= lst;
    do @(posedge clk); while (in_stall);
    if (smooth_step(p, rc, lst, res)) verdict_q.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CONF_MIN: conf_min = value;
      CFG_MARG_MIN: marg_min = value;
      CFG_VOTE_THR: vote_thr = value[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    run_last <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (2 * VOTE_WINDOW + 8) @(negedge clk);
  endtask

  task automatic send_run(output int len);
    int sel;
    int dom;
    logic signed [7:0] rc;
    logic signed [7:0] item_rc;
    logic [15:0] peak;
    logic [15:0] p;
    sel = $urandom_range(0, 99);
    if (sel < 60) len = NUM_CLASSES;
    else if (sel < 75) len = $urandom_range(1, NUM_CLASSES - 1);
    else if (sel < 98) len = $urandom_range(NUM_CLASSES + 1, 20);
    else len = $urandom_range(INDEX_CAP - 2, INDEX_CAP + 13);
    if ($urandom_range(0, 4) == 0) trend_cls = $urandom_range(0, NUM_CLASSES - 1);
    sel = $urandom_range(0, 99);
    if (sel < 75) rc = 8'(trend_cls);
    else if (sel < 88) rc = 8'($urandom_range(0, NUM_CLASSES - 1));
    else rc = 8'($urandom_range(0, 255));
    if (rc >= 0 && rc < NUM_CLASSES && $urandom_range(0, 3) != 0) dom = int'(rc);
    else dom = $urandom_range(0, NUM_CLASSES - 1);
    peak = 16'($urandom_range(28000, 65535));
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 99);
      if (i == dom) p = peak;
      else if (sel < 7) p = peak;
      else if (sel < 17) p = 16'($urandom_range(0, 65535));
      else p = 16'($urandom_range(0, 12000));
      item_rc = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : rc;
      if (i == len - 1) item_rc = rc;
      send_item(p, item_rc, i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int len;
    int sent;
    plan = '{
      '{16'hFFFF, 8'sd0,   1'b1, 1'b1, '{8'd255, 16'hFFFF, 16'd0, 1'b1}},
      '{16'd0,    8'sh80,  1'b0, 1'b0, '0},
      '{16'hFFFF, 8'sh80,  1'b1, 1'b1, '{8'd255, 16'd0, 16'hFFFF, 1'b1}},
      '{16'd40000, 8'sd1,  1'b0, 1'b0, '0},
      '{16'd40000, 8'sd1,  1'b1, 1'b1, '{8'd255, 16'd40000, 16'd0, 1'b1}},
      '{16'd60000, 8'sd7,  1'b0, 1'b0, '0},
      '{16'd100,   8'sd7,  1'b1, 1'b1, '{8'd255, 16'd0, 16'd59900, 1'b1}},
      '{16'd1000,  8'sd2,  1'b0, 1'b0, '0},
      '{16'd2000,  8'sd2,  1'b0, 1'b0, '0},
      '{16'd60000, 8'sd2,  1'b0, 1'b0, '0},
      '{16'd3000,  8'sd2,  1'b0, 1'b0, '0},
      '{16'd0,     8'sd2,  1'b0, 1'b0, '0},
      '{16'd500,   8'sd2,  1'b0, 1'b0, '0},
      '{16'd700,   8'sd2,  1'b0, 1'b0, '0},
      '{16'd800,   8'sd2,  1'b0, 1'b0, '0},
      '{16'hFFFF,  8'sd2,  1'b1, 1'b0, '0},
      '{16'd12345, 8'sh7F, 1'b0, 1'b0, '0},
      '{16'd54321, 8'sh7F, 1'b1, 1'b0, '0},
      '{16'd10000, 8'sd1,  1'b0, 1'b0, '0},
      '{16'd60000, 8'sd1,  1'b1, 1'b0, '0},
      '{16'd10000, 8'sd1,  1'b0, 1'b0, '0},
      '{16'd60000, 8'sd1,  1'b1, 1'b0, '0},
      '{16'd10000, 8'sd1,  1'b0, 1'b0, '0},
      '{16'd60000, 8'sd1,  1'b1, 1'b0, '0},
      '{16'd0,     8'sd3,  1'b1, 1'b1, '{8'd1, 16'd0, 16'd0, 1'b1}}
    };
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_PLAN; i++) begin
      send_item(plan[i].p, plan[i].rc, plan[i].lst, plan[i].typed, plan[i].want);
    end
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(CFG_CONF_MIN, conf_tab[ph]);
      write_reg(CFG_MARG_MIN, marg_tab[ph]);
      write_reg(CFG_VOTE_THR, thr_tab[ph]);
      cfg_valid <= 1'b0;
      pace = pace_tab[ph];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_run(len);
        sent += len;
      end
    end
    in_valid <= 1'b0;
    run_last <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4 * VOTE_WINDOW + 20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
